/* hw/rtl/afu_pkg.sv */
// Shared types, constants and helpers of the activation function unit.
package afu_pkg;

    // Sample format
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int MSB        = DATA_WIDTH - 1;
    localparam int ONE        = 1 << FRAC_BITS;

    // Activation kinds held in the mode register
    typedef enum logic [1:0] {
        MODE_RELU     = 2'd0,
        MODE_LEAKY    = 2'd1,
        MODE_LINEAR   = 2'd2,
        MODE_LOGISTIC = 2'd3
    } mode_t;

    // Leaky slope: floor(x/10) as ceil(|x|/10) = ((|x| + 9) * 52429) >> 19
    localparam int LEAKY_BIAS  = 9;
    localparam int LEAKY_RECIP = 52429;
    localparam int LEAKY_SHIFT = 19;
    localparam int LEAKY_RCP_W = 16;
    localparam int LEAKY_Q_W   = DATA_WIDTH + 1 + LEAKY_RCP_W - LEAKY_SHIFT;

    // Logistic datapath
    localparam int MAG_W        = FRAC_BITS + 4;          // |x| below saturation
    localparam int SAT_LIMIT    = 1 << MAG_W;
    localparam int EXP_FRAC     = 36;                     // fraction bits of exp
    localparam int U_SHIFT      = EXP_FRAC - 5 - FRAC_BITS;
    localparam int MUL_SHIFT    = EXP_FRAC - U_SHIFT;
    localparam int TERM_W       = MAG_W + U_SHIFT;
    localparam int PROD_W       = TERM_W + MAG_W;
    localparam int SUM_W        = EXP_FRAC + 1;
    localparam int DIVX_W       = 32;                     // dividend width, odd divisors
    localparam int TAYLOR_TERMS = 10;                     // later terms truncate to zero
    localparam int SQUARINGS    = 5;
    localparam int SQ_HALF      = 24;
    localparam int EXP_W        = 4 * SQ_HALF - EXP_FRAC;
    localparam int Q_BITS       = 8;
    localparam int DEN_W        = EXP_W + 1;
    localparam int NUM_W        = EXP_W + 2;
    localparam int CMP_W        = DEN_W + 1 + Q_BITS;
    localparam int LOGI_LAT     = 1 + 3 * (TAYLOR_TERMS - 1) + 2 * SQUARINGS + Q_BITS;

    // Side band that rides along the logistic pipeline
    typedef struct packed {
        logic                  last;
        mode_t                 mode;
        logic                  neg;
        logic                  sat;
        logic [DATA_WIDTH-1:0] lin;
    } tag_t;

    // Odd factor of a small divisor
    function automatic int odd_part(input int n);
        int v;
        v = n;
        for (int i = 0; i < 4; i++) begin
            if (v != 0 && v[0] == 1'b0) v = v >> 1;
        end
        return v;
    endfunction

    // Power-of-two factor (as a shift) of a small divisor
    function automatic int two_shift(input int n);
        int v;
        int s;
        v = n;
        s = 0;
        for (int i = 0; i < 4; i++) begin
            if (v != 0 && v[0] == 1'b0) begin
                v = v >> 1;
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

/* hw/rtl/afu_logistic.sv */
// Pipelined logistic core: round(256 / (1 + exp(m/256))) for a 12-bit magnitude.
module afu_logistic (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         vld_in,
    input  logic [afu_pkg::MAG_W-1:0]    mag_in,
    input  afu_pkg::tag_t                tag_in,
    output logic                         vld_out,
    output logic [afu_pkg::Q_BITS-1:0]   q_out,
    output afu_pkg::tag_t                tag_out
);

    localparam int LAT    = afu_pkg::LOGI_LAT;
    localparam int MAG_W  = afu_pkg::MAG_W;
    localparam int TERM_W = afu_pkg::TERM_W;
    localparam int PROD_W = afu_pkg::PROD_W;
    localparam int SUM_W  = afu_pkg::SUM_W;
    localparam int EXP_W  = afu_pkg::EXP_W;
    localparam int HALF   = afu_pkg::SQ_HALF;
    localparam int NT     = afu_pkg::TAYLOR_TERMS;
    localparam int NSQ    = afu_pkg::SQUARINGS;
    localparam int QB     = afu_pkg::Q_BITS;
    localparam int DEN_W  = afu_pkg::DEN_W;
    localparam int NUM_W  = afu_pkg::NUM_W;
    localparam int CMP_W  = afu_pkg::CMP_W;
    localparam int DX_W   = afu_pkg::DIVX_W;

    // valid and side band shift line
    logic [LAT-1:0]  vld_reg;
    afu_pkg::tag_t   tag_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < LAT; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign vld_out = vld_reg[LAT-1];
    assign tag_out = tag_reg[LAT-1];

    // Taylor series of exp(m / 2^13): term_n = floor(term_(n-1) * m / (n * 2^13))
    logic [TERM_W-1:0] term_s [1:NT];
    logic [SUM_W-1:0]  sum_s  [1:NT];
    logic [MAG_W-1:0]  mag_s  [1:NT];

    logic [TERM_W-1:0] term1_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [MAG_W-1:0]  mag1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag_in;
            term1_reg <= TERM_W'(mag_in) << afu_pkg::U_SHIFT;
            sum1_reg  <= (SUM_W'(1) << afu_pkg::EXP_FRAC)
                       + (SUM_W'(mag_in) << afu_pkg::U_SHIFT);
        end
    end

    assign term_s[1] = term1_reg;
    assign sum_s[1]  = sum1_reg;
    assign mag_s[1]  = mag1_reg;

    for (genvar n = 2; n <= NT; n++) begin : g_term
        localparam int         ODD   = afu_pkg::odd_part(n);
        localparam int         SH    = afu_pkg::two_shift(n) + afu_pkg::MUL_SHIFT;
        localparam logic [63:0] RECIP = (64'd1 << DX_W) / ODD;

        logic [PROD_W-1:0] prod_reg;
        logic [MAG_W-1:0]  mag_a_reg, mag_b_reg, mag_c_reg;
        logic [SUM_W-1:0]  sum_a_reg, sum_b_reg, sum_c_reg;
        logic [TERM_W-1:0] x_reg, q0_reg, term_c_reg;
        logic [TERM_W-1:0] x_next, q0_next, rem, term_next;

        assign x_next = TERM_W'(prod_reg >> SH);

        if (ODD == 1) begin : g_pow2
            assign q0_next = x_next;
        end else begin : g_recip
            // estimate is low by at most one, fixed up in the next stage
            logic [2*DX_W-1:0] rprod;
            assign rprod   = x_next[DX_W-1:0] * RECIP[DX_W-1:0];
            assign q0_next = TERM_W'(rprod[2*DX_W-1:DX_W]);
        end

        assign rem       = x_reg - q0_reg * TERM_W'(ODD);
        assign term_next = q0_reg + TERM_W'(rem >= TERM_W'(ODD));

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg   <= term_s[n-1] * mag_s[n-1];
                mag_a_reg  <= mag_s[n-1];
                sum_a_reg  <= sum_s[n-1];
                x_reg      <= x_next;
                q0_reg     <= q0_next;
                mag_b_reg  <= mag_a_reg;
                sum_b_reg  <= sum_a_reg;
                term_c_reg <= term_next;
                sum_c_reg  <= sum_b_reg + SUM_W'(term_next);
                mag_c_reg  <= mag_b_reg;
            end
        end

        assign term_s[n] = term_c_reg;
        assign sum_s[n]  = sum_c_reg;
        assign mag_s[n]  = mag_c_reg;
    end

    // five squarings turn exp(m / 2^13) into exp(m / 2^8)
    logic [EXP_W-1:0] sq_s [0:NSQ];
    assign sq_s[0] = EXP_W'(sum_s[NT]);

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic [HALF-1:0]   hi, lo;
        logic [2*HALF-1:0] aa_reg, ab_reg, bb_reg;
        logic [4*HALF-1:0] full;
        logic [EXP_W-1:0]  s_reg;

        assign hi   = sq_s[k][2*HALF-1:HALF];
        assign lo   = sq_s[k][HALF-1:0];
        assign full = {aa_reg, (2*HALF)'(0)}
                    + ((4*HALF)'(ab_reg) << (HALF + 1))
                    + (4*HALF)'(bb_reg);

        always_ff @(posedge aclk) begin
            if (en) begin
                aa_reg <= hi * hi;
                ab_reg <= hi * lo;
                bb_reg <= lo * lo;
                s_reg  <= full[afu_pkg::EXP_FRAC +: EXP_W];
            end
        end

        assign sq_s[k+1] = s_reg;
    end

    // restoring divide, one quotient bit per stage:
    // q = floor((2^45 + e + 1) / (2 * (e + 1))) in exp fixed point
    logic [NUM_W-1:0] rem_s [0:QB];
    logic [DEN_W-1:0] den_s [0:QB];
    logic [QB-1:0]    qb_s  [0:QB];

    assign den_s[0] = DEN_W'(sq_s[NSQ]) + (DEN_W'(1) << afu_pkg::EXP_FRAC);
    assign rem_s[0] = NUM_W'(den_s[0])
                    + (NUM_W'(1) << (afu_pkg::FRAC_BITS + 1 + afu_pkg::EXP_FRAC));
    assign qb_s[0]  = '0;

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;

        logic [CMP_W-1:0] trial;
        logic             ge;
        logic [NUM_W-1:0] rem_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QB-1:0]    q_reg;

        assign trial = CMP_W'(den_s[j]) << (K + 1);
        assign ge    = CMP_W'(rem_s[j]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg <= ge ? rem_s[j] - NUM_W'(trial) : rem_s[j];
                den_reg <= den_s[j];
                q_reg   <= qb_s[j] | (QB'(ge) << K);
            end
        end

        assign rem_s[j+1] = rem_reg;
        assign den_s[j+1] = den_reg;
        assign qb_s[j+1]  = q_reg;
    end

    assign q_out = qb_s[QB];

endmodule

/* hw/rtl/activation_function_unit_core.sv */
// Top level of the activation function unit: input stage, linear modes, output skid.
//
//  channel   | ports                                  | role
//  ----------+----------------------------------------+------------------------------
//  s_        | s_valid s_ready s_sample_in s_last_in  | Q8.8 sample in, one per transfer
//  m_        | m_valid m_ready m_sample_out m_last_out| activated sample out
//  cfg_      | cfg_we cfg_wdata                       | mode register write, no wait
//
//  One transfer per cycle in and out, sustained while m_ready is high. Every mode takes
//  the same path through the logistic pipeline (46 stages: Taylor terms, five squarings,
//  bit-per-stage divide), so order is kept.
//  Reset (synchronous, aresetn low) empties the pipe and sets the mode to relu.
//  When m_ready is low with a result waiting, the next result parks in the skid stage and
//  the whole pipe holds; s_ready drops only while the skid stage is full or aresetn is low.
module activation_function_unit_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [afu_pkg::DATA_WIDTH-1:0] s_sample_in,
    input  logic                                 s_last_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [afu_pkg::DATA_WIDTH-1:0] m_sample_out,
    output logic                                 m_last_out
);

    localparam int DW  = afu_pkg::DATA_WIDTH;
    localparam int MSB = afu_pkg::MSB;

    // mode register
    afu_pkg::mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= afu_pkg::MODE_RELU;
        end else if (cfg_we) begin
            mode_reg <= afu_pkg::mode_t'(cfg_wdata);
        end
    end

    // pipe moves as one; it holds only while the skid stage is occupied
    logic skid_vld_reg;
    logic out_vld_reg;
    logic en;

    assign en      = !skid_vld_reg;
    assign s_ready = en && aresetn;

    // input stage
    logic                 in_vld_reg;
    logic [DW-1:0]        x_reg;
    logic                 last_reg;
    afu_pkg::mode_t       mode_s0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= s_sample_in;
            last_reg    <= s_last_in;
            mode_s0_reg <= mode_reg;
        end
    end

    // magnitude, sign and the non-logistic result
    logic [DW:0]                    x_ext;
    logic [DW:0]                    mag;
    logic                           x_pos;
    logic [DW:0]                    leaky_num;
    logic [DW+afu_pkg::LEAKY_RCP_W:0] leaky_prod;
    logic [afu_pkg::LEAKY_Q_W-1:0]  leaky_q;
    logic [DW-1:0]                  lin_val;

    assign x_ext      = {x_reg[MSB], x_reg};
    assign mag        = x_reg[MSB] ? (~x_ext + (DW+1)'(1)) : x_ext;
    assign x_pos      = !x_reg[MSB] && (x_reg != '0);
    // ceil(|x| / 10) for the leaky slope; x <= 0 here
    assign leaky_num  = mag + (DW+1)'(afu_pkg::LEAKY_BIAS);
    assign leaky_prod = leaky_num
                      * afu_pkg::LEAKY_RCP_W'(afu_pkg::LEAKY_RECIP);
    assign leaky_q    = leaky_prod[afu_pkg::LEAKY_SHIFT +: afu_pkg::LEAKY_Q_W];

    always_comb begin
        unique case (mode_s0_reg)
            afu_pkg::MODE_RELU:     lin_val = x_pos ? x_reg : '0;
            afu_pkg::MODE_LEAKY:    lin_val = x_pos ? x_reg : (DW'(0) - DW'(leaky_q));
            afu_pkg::MODE_LINEAR:   lin_val = x_reg;
            afu_pkg::MODE_LOGISTIC: lin_val = x_reg;
        endcase
    end

    afu_pkg::tag_t tag_in;

    assign tag_in.last = last_reg;
    assign tag_in.mode = mode_s0_reg;
    assign tag_in.neg  = x_reg[MSB];
    assign tag_in.sat  = mag >= (DW+1)'(afu_pkg::SAT_LIMIT);
    assign tag_in.lin  = lin_val;

    // logistic pipeline, also the delay line for every mode
    logic                        pipe_vld;
    logic [afu_pkg::Q_BITS-1:0]  q_out;
    afu_pkg::tag_t               tag_out;

    afu_logistic u_logistic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (in_vld_reg),
        .mag_in  (mag[afu_pkg::MAG_W-1:0]),
        .tag_in  (tag_in),
        .vld_out (pipe_vld),
        .q_out   (q_out),
        .tag_out (tag_out)
    );

    // logistic of -|x| is q; positive x takes one minus it
    logic [afu_pkg::Q_BITS-1:0] logi_r;
    logic [DW-1:0]              logi_val;
    logic [DW-1:0]              res_val;

    assign logi_r   = tag_out.sat ? '0 : q_out;
    assign logi_val = tag_out.neg ? DW'(logi_r) : (DW'(afu_pkg::ONE) - DW'(logi_r));
    assign res_val  = (tag_out.mode == afu_pkg::MODE_LOGISTIC) ? logi_val : tag_out.lin;

    // output register plus one-entry skid
    logic [DW-1:0] out_data_reg, skid_data_reg;
    logic          out_last_reg, skid_last_reg;
    logic          out_free;

    assign out_free = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) skid_vld_reg <= 1'b0;
        end else if (pipe_vld) begin
            if (out_free) out_vld_reg  <= 1'b1;
            else          skid_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (pipe_vld) begin
            if (out_free) begin
                out_data_reg <= res_val;
                out_last_reg <= tag_out.last;
            end else begin
                skid_data_reg <= res_val;
                skid_last_reg <= tag_out.last;
            end
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_sample_out = out_data_reg;
    assign m_last_out   = out_last_reg;

`ifndef SYNTH
    // skid holds data only behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage full with output register empty");

    // skid fills only after a stalled output transfer
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_ready))
        else $error("skid stage filled without an output stall");

    // logistic of a non-positive value never exceeds one half
    a_logi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld |-> (q_out <= afu_pkg::Q_BITS'(afu_pkg::ONE >> 1)))
        else $error("logistic quotient out of range");

    // leaky slope keeps negative inputs negative
    a_leaky_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && mode_s0_reg == afu_pkg::MODE_LEAKY && x_reg[MSB]) |-> lin_val[MSB])
        else $error("leaky result lost its sign");
`endif

endmodule

/* tb/sv/tb_activation_function_unit_core.sv */
// Self-checking testbench for activation_function_unit_core: relu, leaky relu, linear, logistic.
`timescale 1ns / 100ps

module tb_activation_function_unit_core;

    localparam int DATA_WIDTH = afu_pkg::DATA_WIDTH;
    localparam int FRAC_BITS  = afu_pkg::FRAC_BITS;

    // Q36 arithmetic used by the logistic predictor
    localparam int          Q36_FRAC   = 36;
    localparam bit [63:0]   Q36_ONE    = 64'd1 << Q36_FRAC;
    localparam int          ARG_SHIFT  = Q36_FRAC - 5 - FRAC_BITS;   // |x| / 2^(FRAC_BITS+5)
    localparam int          SAT_MAG    = 1 << (FRAC_BITS + 4);
    localparam int          SERIES_LEN = 20;
    localparam int          SQUARES    = 5;
    localparam int          SAMPLE_MAX = (1 << (DATA_WIDTH - 1)) - 1;
    localparam int          SAMPLE_MIN = -(1 << (DATA_WIDTH - 1));

    // Run control
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES  = 100;
    localparam int ITEMS_PER_RUN = 75;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample;
        logic                         last;
    } sample_beat_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_we      = 1'b0;
    logic [1:0]                   cfg_wdata   = 2'd0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_sample_in = '0;
    logic                         s_last_in   = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [DATA_WIDTH-1:0] m_sample_out;
    logic                         m_last_out;

    sample_beat_t   pending_inputs[$];   // waiting to be driven
    sample_beat_t   due_results[$];      // activations owed by the DUT, oldest first
    afu_pkg::mode_t active_mode = afu_pkg::MODE_RELU;
    int             mismatches  = 0;

    activation_function_unit_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_last_out   (m_last_out)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // (a * b) >> 36, kept to 64 bits
    function automatic bit [63:0] q36_mul(input bit [63:0] a, input bit [63:0] b);
        bit [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[Q36_FRAC +: 64];
    endfunction

    // round(2^FRAC_BITS / (1 + exp(mag / 2^FRAC_BITS))) for mag >= 0.
    // exp comes from a Taylor series on mag / 2^(FRAC_BITS+5) followed by five squarings.
    function automatic int logistic_tail(input int mag);
        bit [63:0] arg;
        bit [63:0] term;
        bit [63:0] total;
        bit [63:0] num;
        bit [63:0] den;
        if (mag >= SAT_MAG) return 0;
        arg   = 64'(mag) << ARG_SHIFT;
        term  = Q36_ONE;
        total = Q36_ONE;
        for (int n = 1; n <= SERIES_LEN; n++) begin
            term  = q36_mul(term, arg) / 64'(n);
            total = total + term;
        end
        repeat (SQUARES) total = q36_mul(total, total);
        num = ((64'd1 << (FRAC_BITS + 1)) << Q36_FRAC) + total + Q36_ONE;
        den = 64'd2 * (total + Q36_ONE);
        return int'(num / den);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] activated(input afu_pkg::mode_t m,
                                                              input logic signed [DATA_WIDTH-1:0] s);
        int x;
        x = s;
        case (m)
            afu_pkg::MODE_RELU: begin
                return (x > 0) ? s : '0;
            end
            afu_pkg::MODE_LEAKY: begin
                // floor(x/10) for non-positive x
                if (x > 0) return s;
                return DATA_WIDTH'(-((-x + 9) / 10));
            end
            afu_pkg::MODE_LINEAR: begin
                return s;
            end
            default: begin
                if (x >= 0) return DATA_WIDTH'((1 << FRAC_BITS) - logistic_tail(x));
                return DATA_WIDTH'(logistic_tail(-x));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps in between.
    // Each accepted transfer is predicted on the spot with the current mode.
    // ------------------------------------------------------------------
    sample_beat_t next_beat;
    int           burst_left = 0;
    int           gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                due_results.push_back('{activated(active_mode, s_sample_in), s_last_in});
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_inputs.size() > 0) begin
                    next_beat = pending_inputs.pop_front();
                    s_valid     <= 1'b1;
                    s_sample_in <= next_beat.sample;
                    s_last_in   <= next_beat.last;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        // mostly short bursts, now and then a long unbroken stream
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: a style is held for a random span.
    //   0 always ready, 1 coin flip, 2 ready when style_tick % 4 == 0, 3 long stalls
    // ------------------------------------------------------------------
    int stall_style = 0;
    int style_span  = 0;
    int style_tick  = 0;

    always @(posedge aclk) begin
        if (style_span == 0) begin
            stall_style = $urandom_range(0, 3);
            style_span  = $urandom_range(64, 256);
        end
        style_span = style_span - 1;
        style_tick = style_tick + 1;
        case (stall_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (style_tick % 4 == 0);
            default: m_ready <= (style_tick % 12 < 4);
        endcase
    end

    // ------------------------------------------------------------------
    // Result monitor and scoreboard
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch %s: expected %0d got %0d (mode %s)",
                 $realtime, what, want, got, active_mode.name());
        mismatches++;
    endtask

    sample_beat_t owed;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected transfer, sample", 0, m_sample_out);
            end else begin
                owed = due_results.pop_front();
                if (m_sample_out !== owed.sample)
                    report_mismatch("sample_out", owed.sample, m_sample_out);
                if (m_last_out !== owed.last)
                    report_mismatch("last_out", owed.last, m_last_out);
            end
        end
    end

    // Watchdog: too long without a transfer on either channel
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d results outstanding", due_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Checked on the falling edge so the clocked blocks have settled.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_inputs.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
    endtask

    // Mode is only changed with the pipe empty.
    task automatic set_mode(input afu_pkg::mode_t m);
        wait_drained();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        active_mode = m;
        @(negedge aclk);
    endtask

    task automatic push_sample(input int value, input bit last);
        pending_inputs.push_back('{DATA_WIDTH'(value), last});
    endtask

    function automatic int random_sample();
        case ($urandom_range(0, 5))
            0, 1:    return int'($signed(DATA_WIDTH'($urandom)));
            2:       return int'($urandom_range(0, 8400)) - 4200;            // logistic region
            3:       return ($urandom_range(0, 1) ? 1 : -1) * (SAT_MAG + int'($urandom_range(0, 6)) - 3);
            4:       return int'($urandom_range(0, 40)) - 20;                // around zero
            default: return $urandom_range(0, 1) ? SAMPLE_MAX - int'($urandom_range(0, 3))
                                                 : SAMPLE_MIN + int'($urandom_range(0, 3));
        endcase
    endfunction

    // Arrays of random length closed by last; one in ten beats gets a stray flag.
    task automatic push_random(input int count);
        int len;
        int i;
        while (count > 0) begin
            len = $urandom_range(1, 16);
            if (len > count) len = count;
            for (i = 0; i < len; i++)
                push_sample(random_sample(),
                            (i == len - 1) || ($urandom_range(0, 9) == 0));
            count = count - len;
        end
    endtask

    afu_pkg::mode_t run_modes[8] = '{afu_pkg::MODE_RELU, afu_pkg::MODE_LOGISTIC,
                                     afu_pkg::MODE_LEAKY, afu_pkg::MODE_LINEAR,
                                     afu_pkg::MODE_LOGISTIC, afu_pkg::MODE_RELU,
                                     afu_pkg::MODE_LEAKY, afu_pkg::MODE_LOGISTIC};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: relu from the reset mode, extremes and zero
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(0, 1'b1);
        push_sample(1, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);

        // leaky: floor rounding on both sides of a multiple of ten
        set_mode(afu_pkg::MODE_LEAKY);
        push_sample(-1, 1'b0);
        push_sample(-9, 1'b0);
        push_sample(-10, 1'b1);
        push_sample(-11, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(7, 1'b1);

        set_mode(afu_pkg::MODE_LINEAR);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(-1, 1'b1);

        // logistic: zero, saturation edges, full scale, +-1.0
        set_mode(afu_pkg::MODE_LOGISTIC);
        push_sample(0, 1'b0);
        push_sample(SAT_MAG - 1, 1'b0);
        push_sample(SAT_MAG, 1'b1);
        push_sample(-(SAT_MAG - 1), 1'b0);
        push_sample(-SAT_MAG, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(1 << FRAC_BITS, 1'b0);
        push_sample(-(1 << FRAC_BITS), 1'b1);

        // Random runs; each pauses halfway until every result is back
        foreach (run_modes[r]) begin
            set_mode(run_modes[r]);
            push_random(ITEMS_PER_RUN / 2);
            wait_drained();
            push_random(ITEMS_PER_RUN - ITEMS_PER_RUN / 2);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered, count", 0, due_results.size());

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/afu_pkg.sv
hw/rtl/afu_logistic.sv
hw/rtl/activation_function_unit_core.sv
tb/sv/tb_activation_function_unit_core.sv
